[sv/iir_direct_form_one_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_top_defines.svh
// Assertion macros used by the filter's checker file.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define IIRDF1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also runs during reset
`define IIRDF1_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants, control types and the microprogram of the IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  // default configuration of the filter
  localparam int ORDER_DEF          = 2;
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // register index port width, tap field width and step counter width
  localparam int CFG_INDEX_W = 4;
  localparam int TAP_W       = 3;
  localparam int PC_W        = 4;

  // datapath operations
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MAC_FIRST,
    OP_MAC_ADD,
    OP_MAC_SUB,
    OP_MAG,
    OP_SCALE_HI,
    OP_SCALE_LO,
    OP_FINISH
  } op_t;

  // step conditions: the step holds until its condition is met
  typedef enum logic [1:0] {
    CD_NONE,
    CD_WAIT_IN,
    CD_WAIT_OUT
  } cond_t;

  // one control word of the microprogram
  typedef struct packed {
    op_t              op;
    logic [TAP_W-1:0] tap;
    cond_t            cond;
    logic             jump;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    op_t              op;
    logic [TAP_W-1:0] tap;
    logic             fire;
  } ctrl_t;

  // microprogram rom: taps index the coefficient registers directly
  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc, input int order);
    ucode_t w;
    int     p;
    p        = int'(pc);
    // unused steps return to start
    w.op     = OP_MAG;
    w.tap    = '0;
    w.cond   = CD_NONE;
    w.jump   = 1'b1;
    w.target = '0;
    if (p == 0) begin
      w.op   = OP_LOAD;
      w.cond = CD_WAIT_IN;
      w.jump = 1'b0;
    end else if (p <= order + 1) begin
      w.op   = (p == 1) ? OP_MAC_FIRST : OP_MAC_ADD;
      w.tap  = TAP_W'(p - 1);
      w.jump = 1'b0;
    end else if (p <= 2 * order + 1) begin
      w.op   = OP_MAC_SUB;
      w.tap  = TAP_W'(p - 1);
      w.jump = 1'b0;
    end else if (p == 2 * order + 2) begin
      w.op   = OP_MAG;
      w.jump = 1'b0;
    end else if (p == 2 * order + 3) begin
      w.op   = OP_SCALE_HI;
      w.jump = 1'b0;
    end else if (p == 2 * order + 4) begin
      w.op   = OP_SCALE_LO;
      w.jump = 1'b0;
    end else if (p == 2 * order + 5) begin
      w.op     = OP_FINISH;
      w.cond   = CD_WAIT_OUT;
      w.jump   = 1'b1;
      w.target = '0;
    end
    return w;
  endfunction

endpackage

[sv/iirdf1_seq.sv]
// ----------------------------------------------------------------------------
// iirdf1_seq
// Step counter and control rom; holds a step until its condition is met.
// ----------------------------------------------------------------------------
module iirdf1_seq
  import iirdf1_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          uword;
  logic            fire;

  // control word of the current step
  always_comb uword = ucode_word(pc_r, ORDER);

  // step condition
  always_comb begin
    unique case (uword.cond)
      CD_NONE:     fire = 1'b1;
      CD_WAIT_IN:  fire = in_valid;
      CD_WAIT_OUT: fire = out_free;
      default:     fire = 1'b0;
    endcase
  end

  // next step: hold, jump or advance
  always_comb begin
    priority if (!fire) begin
      pc_nxt = pc_r;
    end else if (uword.jump) begin
      pc_nxt = uword.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl = '{op: uword.op, tap: uword.tap, fire: fire};

endmodule

[sv/iirdf1_dp.sv]
// ----------------------------------------------------------------------------
// iirdf1_dp
// Delay lines, shared multiplier, accumulator, scaling, rounding, saturation.
// ----------------------------------------------------------------------------
module iirdf1_dp
  import iirdf1_pkg::*;
#(
  parameter int ORDER          = ORDER_DEF,
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  ctrl_t                                                  ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]                         sample,
  input  logic [2*ORDER+1:0][COEF_FRAC_BITS+3:0]                 coef,
  output logic [SAMPLE_WIDTH-1:0]                                result
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COEF_FRAC_BITS + 4;
  localparam int NREG   = 2 * ORDER + 2;
  localparam int ACC_W  = SW + CW + $clog2(2 * ORDER + 1);
  localparam int LO_W   = (ACC_W + 1) / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int A_W    = (SW > LO_W + 1) ? SW : LO_W + 1;
  localparam int B_W    = CW + 1;
  localparam int P_W    = A_W + B_W;
  localparam int SC_W   = ACC_W + CW;
  localparam int SHIFT  = 2 * COEF_FRAC_BITS;
  localparam int Q_W    = SC_W - SHIFT;

  localparam logic [SC_W-1:0] HALF    = SC_W'(1) << (SHIFT - 1);
  localparam logic [Q_W-1:0]  LIM_NEG = Q_W'(1) << (SW - 1);
  localparam logic [Q_W-1:0]  LIM_POS = LIM_NEG - 1'b1;
  localparam logic [SW-1:0]   S_MIN   = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0]   S_MAX   = ~S_MIN;

  logic signed [SW-1:0]    x_r [ORDER+1];
  logic signed [SW-1:0]    y_r [ORDER];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0]        mag_r;
  logic                    neg_r;
  logic [HI_W+CW-1:0]      hi_r;
  logic [SC_W-1:0]         sc_r;
  logic [SC_W-1:0]         sc_nxt;

  logic signed [SW-1:0]    x_sel;
  logic signed [CW-1:0]    c_sel;
  logic signed [CW-1:0]    inv;
  logic [CW-1:0]           inv_mag;
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] mac_term;
  logic [Q_W-1:0]          q;

  // sample and coefficient taps of the current step
  always_comb begin
    x_sel = '0;
    c_sel = '0;
    for (int k = 0; k <= ORDER; k++) begin
      if (ctrl.tap == TAP_W'(k)) x_sel = x_r[k];
    end
    for (int k = 0; k < ORDER; k++) begin
      if (ctrl.tap == TAP_W'(ORDER + 1 + k)) x_sel = y_r[k];
    end
    for (int k = 0; k < NREG; k++) begin
      if (ctrl.tap == TAP_W'(k)) c_sel = $signed(coef[k]);
    end
  end

  // magnitude of the reciprocal lead coefficient
  assign inv     = $signed(coef[NREG-1]);
  assign inv_mag = inv[CW-1] ? (~coef[NREG-1] + 1'b1) : coef[NREG-1];

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.op)
      OP_SCALE_HI: begin
        mul_a = A_W'(mag_r[ACC_W-1:LO_W]);
        mul_b = B_W'(inv_mag);
      end
      OP_SCALE_LO: begin
        mul_a = A_W'(mag_r[LO_W-1:0]);
        mul_b = B_W'(inv_mag);
      end
      default: begin
        mul_a = A_W'(x_sel);
        mul_b = B_W'(c_sel);
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign mac_term = ACC_W'($signed(prod[SW+CW-1:0]));

  // accumulate
  always_comb begin
    unique case (ctrl.op)
      OP_MAC_FIRST: acc_nxt = mac_term;
      OP_MAC_ADD:   acc_nxt = acc_r + mac_term;
      OP_MAC_SUB:   acc_nxt = acc_r - mac_term;
      default:      acc_nxt = acc_r;
    endcase
  end

  // scaled magnitude plus half for round to nearest
  assign sc_nxt = (SC_W'(hi_r) << LO_W) + SC_W'(prod[LO_W+CW-1:0]) + HALF;

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_MAC_FIRST, OP_MAC_ADD, OP_MAC_SUB: acc_r <= acc_nxt;
        OP_MAG: begin
          neg_r <= acc_r[ACC_W-1] ^ inv[CW-1];
          mag_r <= acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
        end
        OP_SCALE_HI: hi_r <= prod[HI_W+CW-1:0];
        OP_SCALE_LO: sc_r <= sc_nxt;
        default: ;
      endcase
    end
  end

  // round away from zero on ties, then saturate
  assign q = sc_r[SC_W-1:SHIFT];
  always_comb begin
    if (neg_r) begin
      result = (q >= LIM_NEG) ? S_MIN : (SW'(0) - q[SW-1:0]);
    end else begin
      result = (q > LIM_POS) ? S_MAX : q[SW-1:0];
    end
  end

  // input and output delay lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ORDER; k++) x_r[k] <= '0;
      for (int k = 0; k < ORDER; k++) y_r[k] <= '0;
    end else if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          for (int k = ORDER; k >= 1; k--) x_r[k] <= x_r[k-1];
          x_r[0] <= sample;
        end
        OP_FINISH: begin
          for (int k = ORDER - 1; k >= 1; k--) y_r[k] <= y_r[k-1];
          y_r[0] <= $signed(result);
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/iir_direct_form_one_filter_top.sv]
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_top
// Direct form I IIR filter run by a microprogram over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  ports                          direction  moves
//  input    in_valid/in_ready/in_sample_in  in         one sample word
//  output   out_valid/out_ready/out_sample_out out     one filtered word
//  config   cfg_we/cfg_index/cfg_wdata      in         one coefficient write
//
//  out_valid rises after the finishing step; a new word is taken only at the load
//  step, so one word runs through all the steps before the next: the load step,
//  one step per tap of the shared multiply-accumulate, magnitude,
//  two scaling products and the round/saturate step.
//  the next word is taken while the last result still waits in the output register.
//  a stalled output holds the finishing step until the output register frees up.
//  synchronous reset zeroes the delay lines and loads the default coefficients.
module iir_direct_form_one_filter_top
  import iirdf1_pkg::*;
#(
  parameter int ORDER          = ORDER_DEF,
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [COEF_FRAC_BITS+3:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out
);

  localparam int CW   = COEF_FRAC_BITS + 4;
  localparam int NREG = 2 * ORDER + 2;
  localparam logic [CW-1:0] ONE = CW'(1) << COEF_FRAC_BITS;

  logic [NREG-1:0][CW-1:0]   coef_r;
  logic                      out_valid_r;
  logic [SAMPLE_WIDTH-1:0]   out_sample_r;
  logic [SAMPLE_WIDTH-1:0]   result;
  logic                      out_free;
  logic                      finish;
  ctrl_t                     ctrl;

  // coefficient registers; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NREG; k++) begin
        coef_r[k] <= (k == 0 || k == NREG - 1) ? ONE : '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < NREG; k++) begin
        if (cfg_index == CFG_INDEX_W'(k)) coef_r[k] <= cfg_wdata;
      end
    end
  end

  // sequencer
  iirdf1_seq #(
    .ORDER (ORDER)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // datapath
  iirdf1_dp #(
    .ORDER          (ORDER),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sample (in_sample_in),
    .coef   (coef_r),
    .result (result)
  );

  // handshake
  assign in_ready = (ctrl.op == OP_LOAD);
  assign out_free = !out_valid_r || out_ready;
  assign finish   = ctrl.fire && (ctrl.op == OP_FINISH);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_sample_r <= result;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = $signed(out_sample_r);

endmodule

[sv/iirdf1_checker.sv]
// ----------------------------------------------------------------------------
// iirdf1_checker
// Port-level assertions for the IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "iir_direct_form_one_filter_top_defines.svh"

module iirdf1_checker
  import iirdf1_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out
);

  // reset empties the output register
  `IIRDF1_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

  // a stalled result word holds
  `IIRDF1_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sample_out), "output word changed while stalled")

  // one word at a time: no accept right after an accept
  `IIRDF1_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready, "input ready right after accept")

  // a new result coincides with the program back at its input step
  `IIRDF1_ASSERT(a_result_restart, $rose(out_valid) |-> in_ready, "result shown but input not ready")

endmodule

bind iir_direct_form_one_filter_top iirdf1_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf1_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);
